[src/hvmps_pkg.sv]
// Package for the max-plus Viterbi step block: field widths, defaults and the item kind codes.
// Depends on nothing; the channels, the block, its RAM and its checker take names from it.
package hvmps_pkg;

    // Fixed widths of the channel fields.
    localparam int KIND_BITS      = 2;
    localparam int STATE_IDX_BITS = 4;
    localparam int IN_SCORE_BITS  = 24;
    localparam int COUNT_BITS     = 5;

    // Built defaults of the block.
    localparam int MAX_STATES_DEFAULT = 16;
    localparam int SCORE_BITS_DEFAULT = 24;

    // State count after reset, before it is clamped to the built maximum.
    localparam int STATE_COUNT_RESET = 16;

    // What one input item asks for.
    typedef enum logic [KIND_BITS-1:0] {
        KIND_WRITE_TRANS = 2'd0,
        KIND_WRITE_INIT  = 2'd1,
        KIND_RELOAD      = 2'd2,
        KIND_EMISSION    = 2'd3
    } kind_t;

endpackage

[src/hvmps_channels.sv]
// Valid/ready channel interfaces of the max-plus Viterbi step block: command, result, config.
// Depends on hvmps_pkg for the field widths and the kind type.

interface hvmps_cmd_if;
    logic                                        valid;
    logic                                        ready;
    hvmps_pkg::kind_t                            kind;
    logic [hvmps_pkg::STATE_IDX_BITS-1:0]        from_state;
    logic [hvmps_pkg::STATE_IDX_BITS-1:0]        to_state;
    logic signed [hvmps_pkg::IN_SCORE_BITS-1:0]  score;

    modport source (output valid, output kind, output from_state, output to_state,
                    output score, input ready);
    modport sink   (input valid, input kind, input from_state, input to_state,
                    input score, output ready);
endinterface

interface hvmps_res_if;
    logic                                 valid;
    logic                                 ready;
    logic [hvmps_pkg::STATE_IDX_BITS-1:0] best_state;
    logic                                 step_done;

    modport source (output valid, output best_state, output step_done, input ready);
    modport sink   (input valid, input best_state, input step_done, output ready);
endinterface

interface hvmps_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [hvmps_pkg::COUNT_BITS-1:0] state_count;

    modport source (output valid, output state_count, input ready);
    modport sink   (input valid, input state_count, output ready);
endinterface

[src/hvmps_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// Depends on hvmps_pkg for its default geometry only.
module hvmps_ram #(
    parameter int WIDTH = hvmps_pkg::SCORE_BITS_DEFAULT,
    parameter int DEPTH = hvmps_pkg::MAX_STATES_DEFAULT
) (
    input  logic                                        clk,
    input  logic                                        wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                            wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[src/hmm_viterbi_max_plus_step.sv]
// Top level of the max-plus (log-domain) Viterbi step block for a hidden Markov model.
// Depends on hvmps_pkg, the channel interfaces in hvmps_channels.sv and hvmps_ram.
//
// Usage.
// The cmd channel takes one item per handshake. Its kind writes one transition score, writes
// one initial score, reloads the path scores from the initial table, or supplies the emission
// score of the next state in index order. Every item gives exactly one result item on the res
// channel: the index of the currently most likely state, and step_done when the item was the
// emission of the last active state and so completed a full update step.
// The cfg channel writes the state count (clamped to 1..MAX_STATES). It is taken only while
// the block is idle; it abandons a partial step and rescans the path scores for the new best
// state, during which cmd is not ready.
//
// Passes. Path scores, next scores, the transition table and the initial table each sit in a
// RAM with one read port, so every pass over the states reads one entry per cycle. Table
// writes run no pass; an emission item runs a max pass, a reload runs a copy pass and a
// normalize pass, and the emission that ends a step runs a max pass, a copy pass and a
// normalize pass; the normalize pass is skipped when every copied score is impossible.
// A result is loaded into the output register as the block returns to idle for the next item.
// Reset clears the path scores to impossible through per-entry valid bits, sets the state count
// to min(16, MAX_STATES) and empties the output register; the tables hold nothing until written.
// The output register lets the next item be taken while a result waits; if the receiver
// still stalls when that item is finished, the block holds it until the register frees up.
module hmm_viterbi_max_plus_step #(
    parameter int MAX_STATES = hvmps_pkg::MAX_STATES_DEFAULT,
    parameter int SCORE_BITS = hvmps_pkg::SCORE_BITS_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    hvmps_cmd_if.sink    cmd,
    hvmps_res_if.source  res,
    hvmps_cfg_if.sink    cfg
);

    localparam int IDX_W    = $clog2(MAX_STATES);
    localparam int CNT_W    = $clog2(MAX_STATES + 1);
    localparam int TA_DEPTH = MAX_STATES * MAX_STATES;
    localparam int TA_W     = $clog2(TA_DEPTH);
    localparam int IN_W     = hvmps_pkg::IN_SCORE_BITS;
    localparam int CMP_W    = ((SCORE_BITS > IN_W) ? SCORE_BITS : IN_W) + 1;
    localparam int RESET_N  = (hvmps_pkg::STATE_COUNT_RESET > MAX_STATES) ?
                              MAX_STATES : hvmps_pkg::STATE_COUNT_RESET;

    typedef logic signed [SCORE_BITS-1:0] score_t;

    // The minimum value stands for log(0), an impossible state.
    localparam score_t SCORE_MIN = {1'b1, {(SCORE_BITS-1){1'b0}}};
    localparam score_t SCORE_MAX = {1'b0, {(SCORE_BITS-1){1'b1}}};
    localparam logic signed [SCORE_BITS:0] WIDE_MIN = {2'b11, {(SCORE_BITS-1){1'b0}}};
    localparam logic signed [SCORE_BITS:0] WIDE_MAX = {2'b00, {(SCORE_BITS-1){1'b1}}};
    localparam logic signed [IN_W-1:0] IN_IMPOSSIBLE = {1'b1, {(IN_W-1){1'b0}}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RESCAN,
        ST_EMIT,
        ST_COPY,
        ST_NORM,
        ST_FINISH
    } state_t;

    // Saturate a one-bit-wider sum: anything at or below the minimum is impossible.
    function automatic score_t sat_wide(input logic signed [SCORE_BITS:0] v);
        if (v <= WIDE_MIN)
        begin
            return SCORE_MIN;
        end
        if (v > WIDE_MAX)
        begin
            return SCORE_MAX;
        end
        return v[SCORE_BITS-1:0];
    endfunction

    // Max-plus product: an impossible operand keeps the result impossible.
    function automatic score_t sat_add(input score_t a, input score_t b);
        logic signed [SCORE_BITS:0] s;
        s = {a[SCORE_BITS-1], a} + {b[SCORE_BITS-1], b};
        if (a == SCORE_MIN || b == SCORE_MIN)
        begin
            return SCORE_MIN;
        end
        return sat_wide(s);
    endfunction

    function automatic score_t sat_sub(input score_t a, input score_t b);
        logic signed [SCORE_BITS:0] s;
        s = {a[SCORE_BITS-1], a} - {b[SCORE_BITS-1], b};
        return sat_wide(s);
    endfunction

    // Bring a channel score into the internal format, keeping the impossible code.
    function automatic score_t input_score(input logic signed [IN_W-1:0] raw);
        logic signed [CMP_W-1:0] v;
        logic signed [CMP_W-1:0] lo;
        logic signed [CMP_W-1:0] hi;
        v  = CMP_W'(raw);
        lo = CMP_W'(SCORE_MIN);
        hi = CMP_W'(SCORE_MAX);
        if (raw == IN_IMPOSSIBLE)
        begin
            return SCORE_MIN;
        end
        if (v <= lo)
        begin
            return SCORE_MIN;
        end
        if (v > hi)
        begin
            return SCORE_MAX;
        end
        return SCORE_BITS'(v);
    endfunction

    // Control and datapath registers.
    state_t                state_reg,     state_next;
    logic [CNT_W-1:0]      n_reg,         n_next;
    logic [IDX_W-1:0]      eidx_reg,      eidx_next;
    logic [CNT_W-1:0]      cnt_reg,       cnt_next;
    logic                  pend_reg,      pend_next;
    logic [IDX_W-1:0]      pend_idx_reg,  pend_idx_next;
    score_t                acc_reg,       acc_next;
    logic [IDX_W-1:0]      arg_reg,       arg_next;
    logic [IDX_W-1:0]      best_reg,      best_next;
    score_t                score_reg,     score_next;
    logic [IDX_W-1:0]      j_reg,         j_next;
    logic                  last_reg,      last_next;
    logic                  from_init_reg, from_init_next;
    logic                  done_reg,      done_next;
    logic [MAX_STATES-1:0] path_vld_reg,  path_vld_next;
    logic                  res_valid_reg, res_valid_next;
    logic [hvmps_pkg::STATE_IDX_BITS-1:0] res_best_reg, res_best_next;
    logic                  res_done_reg,  res_done_next;

    // RAM ports.
    score_t            path_rdata;
    score_t            next_rdata;
    score_t            trans_rdata;
    score_t            init_rdata;
    logic              path_we;
    score_t            path_wr_data;
    logic              next_we;
    score_t            next_wr_data;
    logic              trans_we;
    logic [TA_W-1:0]   trans_wr_addr;
    logic [TA_W-1:0]   trans_rd_addr;
    logic              init_we;
    logic [IDX_W-1:0]  init_wr_addr;

    // Handshakes and decoded command fields.
    logic              cmd_acc;
    logic              cfg_acc;
    score_t            cmd_score;
    logic              from_ok;
    logic              to_ok;
    logic [CNT_W-1:0]  cfg_n;
    logic [IDX_W-1:0]  j_cur;
    logic              last_cur;

    // Pass sequencing.
    logic              in_pass;
    logic              issue;
    logic              pass_end;
    logic [IDX_W-1:0]  rd_idx;
    score_t            path_cur;
    score_t            emit_cand;
    score_t            copy_val;
    score_t            norm_val;
    score_t            cand;
    logic              track;

    assign cfg.ready = (state_reg == ST_IDLE);
    assign cmd.ready = (state_reg == ST_IDLE) && !cfg.valid;
    assign cfg_acc   = cfg.valid && cfg.ready;
    assign cmd_acc   = cmd.valid && cmd.ready;

    assign res.valid      = res_valid_reg;
    assign res.best_state = res_best_reg;
    assign res.step_done  = res_done_reg;

    assign cmd_score     = input_score(cmd.score);
    assign from_ok       = (int'(cmd.from_state) < MAX_STATES);
    assign to_ok         = (int'(cmd.to_state) < MAX_STATES);
    assign trans_wr_addr = TA_W'(int'(cmd.from_state) * MAX_STATES + int'(cmd.to_state));
    assign init_wr_addr  = IDX_W'(cmd.from_state);
    assign trans_we      = cmd_acc && (cmd.kind == hvmps_pkg::KIND_WRITE_TRANS) &&
                           from_ok && to_ok;
    assign init_we       = cmd_acc && (cmd.kind == hvmps_pkg::KIND_WRITE_INIT) && from_ok;

    // A state count of zero means one state; counts above the built size are clamped.
    always_comb
    begin
        if (cfg.state_count == '0)
        begin
            cfg_n = CNT_W'(1);
        end
        else if (int'(cfg.state_count) > MAX_STATES)
        begin
            cfg_n = CNT_W'(MAX_STATES);
        end
        else
        begin
            cfg_n = CNT_W'(cfg.state_count);
        end
    end

    assign j_cur    = (CNT_W'(eidx_reg) < n_reg) ? eidx_reg : '0;
    assign last_cur = (CNT_W'(j_cur) + CNT_W'(1)) >= n_reg;

    // Every pass issues one read per cycle for states 0..N-1, handling the data the cycle after.
    assign in_pass  = (state_reg == ST_RESCAN) || (state_reg == ST_EMIT) ||
                      (state_reg == ST_COPY) || (state_reg == ST_NORM);
    assign issue    = (cnt_reg != n_reg);
    assign pass_end = !issue && !pend_reg;
    assign rd_idx   = cnt_reg[IDX_W-1:0];

    assign trans_rd_addr = TA_W'(TA_W'(rd_idx) * TA_W'(MAX_STATES) + TA_W'(j_reg));

    // Path entries that were never written since reset read as impossible.
    assign path_cur  = path_vld_reg[pend_idx_reg] ? path_rdata : SCORE_MIN;
    assign emit_cand = sat_add(path_cur, trans_rdata);
    assign copy_val  = from_init_reg ? init_rdata : next_rdata;
    // During the normalize pass acc_reg holds the maximum found by the copy pass.
    assign norm_val  = (path_rdata == SCORE_MIN) ? SCORE_MIN : sat_sub(path_rdata, acc_reg);

    assign next_we      = (state_reg == ST_EMIT) && pass_end;
    assign next_wr_data = sat_add(acc_reg, score_reg);
    assign path_we      = ((state_reg == ST_COPY) || (state_reg == ST_NORM)) && pend_reg;
    assign path_wr_data = (state_reg == ST_COPY) ? copy_val : norm_val;

    always_comb
    begin
        unique case (state_reg)
            ST_RESCAN:
            begin
                cand  = path_cur;
                track = 1'b1;
            end
            ST_EMIT:
            begin
                cand  = emit_cand;
                track = 1'b1;
            end
            ST_COPY:
            begin
                cand  = copy_val;
                track = 1'b1;
            end
            default:
            begin
                cand  = acc_reg;
                track = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        eidx_next      = eidx_reg;
        cnt_next       = cnt_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        acc_next       = acc_reg;
        arg_next       = arg_reg;
        best_next      = best_reg;
        score_next     = score_reg;
        j_next         = j_reg;
        last_next      = last_reg;
        from_init_next = from_init_reg;
        done_next      = done_reg;
        path_vld_next  = path_vld_reg;
        res_valid_next = res_valid_reg && !res.ready;
        res_best_next  = res_best_reg;
        res_done_next  = res_done_reg;

        if (in_pass)
        begin
            if (issue)
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
            pend_next     = issue;
            pend_idx_next = rd_idx;
            // Strictly greater keeps the lowest index on ties.
            if (track && pend_reg && (cand > acc_reg))
            begin
                acc_next = cand;
                arg_next = pend_idx_reg;
            end
        end

        if ((state_reg == ST_COPY) && pend_reg)
        begin
            path_vld_next[pend_idx_reg] = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                cnt_next  = '0;
                pend_next = 1'b0;
                acc_next  = SCORE_MIN;
                arg_next  = '0;
                if (cfg_acc)
                begin
                    n_next     = cfg_n;
                    eidx_next  = '0;
                    state_next = ST_RESCAN;
                end
                else if (cmd_acc)
                begin
                    done_next = 1'b0;
                    unique case (cmd.kind)
                        hvmps_pkg::KIND_WRITE_TRANS,
                        hvmps_pkg::KIND_WRITE_INIT:
                        begin
                            state_next = ST_FINISH;
                        end
                        hvmps_pkg::KIND_RELOAD:
                        begin
                            eidx_next      = '0;
                            from_init_next = 1'b1;
                            state_next     = ST_COPY;
                        end
                        hvmps_pkg::KIND_EMISSION:
                        begin
                            j_next     = j_cur;
                            last_next  = last_cur;
                            score_next = cmd_score;
                            eidx_next  = last_cur ? '0 : (j_cur + IDX_W'(1));
                            state_next = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_RESCAN:
            begin
                if (pass_end)
                begin
                    best_next  = arg_reg;
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                // The next score of this state is written as the pass ends.
                if (pass_end)
                begin
                    if (last_reg)
                    begin
                        cnt_next       = '0;
                        acc_next       = SCORE_MIN;
                        arg_next       = '0;
                        from_init_next = 1'b0;
                        done_next      = 1'b1;
                        state_next     = ST_COPY;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_COPY:
            begin
                // Normalizing keeps the order of the scores, so the best state is known here.
                if (pass_end)
                begin
                    best_next = arg_reg;
                    if (acc_reg == SCORE_MIN)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        cnt_next   = '0;
                        state_next = ST_NORM;
                    end
                end
            end
            ST_NORM:
            begin
                if (pass_end)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!res_valid_reg || res.ready)
                begin
                    res_valid_next = 1'b1;
                    res_best_next  = hvmps_pkg::STATE_IDX_BITS'(best_reg);
                    res_done_next  = done_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            n_reg         <= CNT_W'(RESET_N);
            eidx_reg      <= '0;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            pend_idx_reg  <= '0;
            acc_reg       <= SCORE_MIN;
            arg_reg       <= '0;
            best_reg      <= '0;
            score_reg     <= SCORE_MIN;
            j_reg         <= '0;
            last_reg      <= 1'b0;
            from_init_reg <= 1'b0;
            done_reg      <= 1'b0;
            path_vld_reg  <= '0;
            res_valid_reg <= 1'b0;
            res_best_reg  <= '0;
            res_done_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            eidx_reg      <= eidx_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            pend_idx_reg  <= pend_idx_next;
            acc_reg       <= acc_next;
            arg_reg       <= arg_next;
            best_reg      <= best_next;
            score_reg     <= score_next;
            j_reg         <= j_next;
            last_reg      <= last_next;
            from_init_reg <= from_init_next;
            done_reg      <= done_next;
            path_vld_reg  <= path_vld_next;
            res_valid_reg <= res_valid_next;
            res_best_reg  <= res_best_next;
            res_done_reg  <= res_done_next;
        end
    end

    // Current path scores; entries above the active count keep their values.
    hvmps_ram #(
        .WIDTH (SCORE_BITS),
        .DEPTH (MAX_STATES)
    ) u_path_ram (
        .clk     (clk),
        .wr_en   (path_we),
        .wr_addr (pend_idx_reg),
        .wr_data (path_wr_data),
        .rd_addr (rd_idx),
        .rd_data (path_rdata)
    );

    // Scores of the step in progress; each one is written before the copy pass reads it.
    hvmps_ram #(
        .WIDTH (SCORE_BITS),
        .DEPTH (MAX_STATES)
    ) u_next_ram (
        .clk     (clk),
        .wr_en   (next_we),
        .wr_addr (j_reg),
        .wr_data (next_wr_data),
        .rd_addr (rd_idx),
        .rd_data (next_rdata)
    );

    // Transition scores, row-major by source state.
    hvmps_ram #(
        .WIDTH (SCORE_BITS),
        .DEPTH (TA_DEPTH)
    ) u_trans_ram (
        .clk     (clk),
        .wr_en   (trans_we),
        .wr_addr (trans_wr_addr),
        .wr_data (cmd_score),
        .rd_addr (trans_rd_addr),
        .rd_data (trans_rdata)
    );

    hvmps_ram #(
        .WIDTH (SCORE_BITS),
        .DEPTH (MAX_STATES)
    ) u_init_ram (
        .clk     (clk),
        .wr_en   (init_we),
        .wr_addr (init_wr_addr),
        .wr_data (cmd_score),
        .rd_addr (rd_idx),
        .rd_data (init_rdata)
    );

endmodule

[src/hvmps_checker.sv]
// Port-level checker for the max-plus Viterbi step block, and the bind that attaches it.
// Depends on hvmps_pkg and on the ports of hmm_viterbi_max_plus_step.
module hvmps_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 cmd_valid,
    input logic                                 cmd_ready,
    input logic                                 res_valid,
    input logic                                 res_ready,
    input logic [hvmps_pkg::STATE_IDX_BITS-1:0] res_best_state,
    input logic                                 res_step_done,
    input logic                                 cfg_valid,
    input logic                                 cfg_ready
);

    logic       cmd_acc;
    logic       res_acc;
    logic       cfg_acc;
    logic [1:0] open_reg, open_next;

    assign cmd_acc = cmd_valid && cmd_ready;
    assign res_acc = res_valid && res_ready;
    assign cfg_acc = cfg_valid && cfg_ready;

    // Items taken whose result has not been delivered yet.
    always_comb
    begin
        open_next = open_reg + {1'b0, cmd_acc} - {1'b0, res_acc};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= '0;
        end
        else
        begin
            open_reg <= open_next;
        end
    end

    // A stalled result holds still.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_best_state) &&
        $stable(res_step_done))
        else $error("result changed while stalled");

    // Every delivered result belongs to an item taken earlier.
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        res_acc |-> open_reg != 2'd0)
        else $error("result without an outstanding item");

    // At most one item in work and one result waiting.
    a_open_bound: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg != 2'd3)
        else $error("too many items outstanding");

    // A configuration write and an item are never taken together.
    a_cfg_excl: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_acc |-> !cmd_acc)
        else $error("configuration write taken together with an item");

    // The best-state rescan after a configuration write keeps items out.
    a_cfg_rescan: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_acc |=> !cmd_ready)
        else $error("item port ready right after a configuration write");

endmodule

bind hmm_viterbi_max_plus_step hvmps_checker u_hvmps_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (cmd.valid),
    .cmd_ready      (cmd.ready),
    .res_valid      (res.valid),
    .res_ready      (res.ready),
    .res_best_state (res.best_state),
    .res_step_done  (res.step_done),
    .cfg_valid      (cfg.valid),
    .cfg_ready      (cfg.ready)
);

[sim/hvmps_tb_pkg.sv]
// Scoreboard of the max-plus Viterbi step testbench: the score types and a cycle-free tracker.
// Depends on hvmps_pkg for the kind codes, the field widths and the built sizes of the block.
package hvmps_tb_pkg;

    import hvmps_pkg::*;

    localparam int STATES  = MAX_STATES_DEFAULT;
    localparam int SCORE_W = SCORE_BITS_DEFAULT;

    typedef logic signed [SCORE_W-1:0]  score_t;
    typedef logic [STATE_IDX_BITS-1:0]  state_idx_t;

    // The most negative score stands for log(0).
    localparam score_t IMPOSSIBLE = {1'b1, {(SCORE_W-1){1'b0}}};
    localparam score_t TOP_SCORE  = {1'b0, {(SCORE_W-1){1'b1}}};

    typedef struct packed {
        state_idx_t best_state;
        logic       step_done;
    } step_report_t;

    class viterbi_scoreboard;
        score_t       path_score[STATES];
        score_t       step_score[STATES];
        score_t       trans_score[STATES][STATES];
        score_t       init_score[STATES];
        int unsigned  emit_idx;
        int unsigned  count_reg;
        step_report_t awaited[$];
        int           errors;
        int           steps_done;
        int           reloads;
        int           items;

        function new();
            foreach (path_score[i])
            begin
                path_score[i] = IMPOSSIBLE;
                step_score[i] = IMPOSSIBLE;
                init_score[i] = '0;
            end
            foreach (trans_score[i, j])
                trans_score[i][j] = '0;
            emit_idx   = 0;
            count_reg  = STATE_COUNT_RESET;
            errors     = 0;
            steps_done = 0;
            reloads    = 0;
            items      = 0;
        endfunction

        function int unsigned active_count();
            if (count_reg < 1)
                return 1;
            if (count_reg > STATES)
                return STATES;
            return count_reg;
        endfunction

        function score_t saturate(longint v);
            if (v <= longint'(IMPOSSIBLE))
                return IMPOSSIBLE;
            if (v > longint'(TOP_SCORE))
                return TOP_SCORE;
            return score_t'(v);
        endfunction

        // Anything plus log(0) stays log(0).
        function score_t add_scores(score_t a, score_t b);
            if (a == IMPOSSIBLE || b == IMPOSSIBLE)
                return IMPOSSIBLE;
            return saturate(longint'(a) + longint'(b));
        endfunction

        function void normalize(int unsigned n);
            score_t top;
            top = path_score[0];
            for (int unsigned i = 1; i < n; i++)
                if (path_score[i] > top)
                    top = path_score[i];
            if (top == IMPOSSIBLE)
                return;
            for (int unsigned i = 0; i < n; i++)
                if (path_score[i] != IMPOSSIBLE)
                    path_score[i] = saturate(longint'(path_score[i]) - longint'(top));
        endfunction

        function state_idx_t leader(int unsigned n);
            int unsigned best;
            best = 0;
            for (int unsigned i = 1; i < n; i++)
                if (path_score[i] > path_score[best])
                    best = i;
            return state_idx_t'(best);
        endfunction

        function void note_config(logic [COUNT_BITS-1:0] value);
            count_reg = value;
            emit_idx  = 0;
        endfunction

        function void note_item(kind_t kind, state_idx_t from, state_idx_t to,
                                logic signed [IN_SCORE_BITS-1:0] raw);
            int unsigned  n;
            int unsigned  j;
            score_t       s;
            score_t       best;
            score_t       cand;
            step_report_t report;
            n = active_count();
            // The input minimum saturates to log(0); other values clamp to the score range.
            s = saturate(longint'(raw));
            report.step_done = 1'b0;
            items++;
            case (kind)
                KIND_WRITE_TRANS:
                    trans_score[from][to] = s;
                KIND_WRITE_INIT:
                    init_score[from] = s;
                KIND_RELOAD:
                begin
                    for (int unsigned i = 0; i < n; i++)
                        path_score[i] = init_score[i];
                    foreach (step_score[i])
                        step_score[i] = IMPOSSIBLE;
                    normalize(n);
                    emit_idx = 0;
                    reloads++;
                end
                default:
                begin
                    j = emit_idx;
                    if (j >= n)
                        j = 0;
                    best = IMPOSSIBLE;
                    for (int unsigned i = 0; i < n; i++)
                    begin
                        cand = add_scores(path_score[i], trans_score[i][j]);
                        if (cand > best)
                            best = cand;
                    end
                    step_score[j] = add_scores(best, s);
                    if (j + 1 >= n)
                    begin
                        for (int unsigned i = 0; i < n; i++)
                            path_score[i] = step_score[i];
                        normalize(n);
                        emit_idx = 0;
                        report.step_done = 1'b1;
                        steps_done++;
                    end
                    else
                        emit_idx = j + 1;
                end
            endcase
            report.best_state = leader(n);
            awaited.push_back(report);
        endfunction

        function void check_result(state_idx_t best, logic done);
            step_report_t want;
            if (awaited.size() == 0)
            begin
                $error("result with no item waiting: best_state=%0d step_done=%0b", best, done);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (best !== want.best_state)
            begin
                $error("best_state mismatch: expected %0d, actual %0d", want.best_state, best);
                errors++;
            end
            if (done !== want.step_done)
            begin
                $error("step_done mismatch: expected %0b, actual %0b", want.step_done, done);
                errors++;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void flag_leftovers();
            if (awaited.size() != 0)
            begin
                $error("%0d expected results never arrived", awaited.size());
                errors++;
            end
        endfunction
    endclass

endpackage

[sim/hmm_viterbi_max_plus_step_test.sv]
// Testbench top of the max-plus Viterbi step block: drives its three channels and checks results.
// Depends on hvmps_pkg, the channel interfaces, hvmps_tb_pkg and the block itself.
module hmm_viterbi_max_plus_step_test;

    timeunit 1ns;
    timeprecision 1ps;

    import hvmps_pkg::*;
    import hvmps_tb_pkg::*;

    // The slowest item is the emission that ends a step at N = 16; with the
    // longest gap and stall on top, a few thousand items stay far below this limit.
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 3 * STATES + 16;
    localparam int RANDOM_ITEMS  = 1350;
    localparam int PHASE_ITEMS   = 140;

    // State counts of the random phases, in order. The extremes come early, and the list
    // also holds values that are clamped (zero and anything above the built maximum).
    localparam int COUNT_PLAN [12] = '{16, 1, 0, 31, 17, 4, 9, 3, 16, 2, 7, 12};

    logic clk;
    logic rst_n;

    hvmps_cmd_if cmd ();
    hvmps_res_if res ();
    hvmps_cfg_if cfg ();

    hmm_viterbi_max_plus_step dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .res   (res),
        .cfg   (cfg)
    );

    viterbi_scoreboard sb = new();

    // Stimulus bookkeeping. The tables must never be read where they were not written, so
    // the generator remembers which entries hold a value and fills the rest before any
    // emission or reload touches them.
    bit          idle_on;
    int          active_n;
    int          sent_items;
    int          random_items;
    int          settings_used;
    bit          trans_set [STATES][STATES];
    bit          init_set [STATES];
    int unsigned cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // Watchdog: a hung handshake or a lost result ends the run here.
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Run stopped after %0d cycles without finishing", cycle_count);
        $display("** hmm_viterbi_max_plus_step: FAILED **");
        $finish;
    end

    // Monitors sample at the rising edge, so they see the values that were present during
    // the cycle that ends there. An item noted at an edge can never have its result at the
    // same edge, so the order of the two calls below does not matter.
    always @(posedge clk)
    begin
        if (rst_n && cmd.valid && cmd.ready)
            sb.note_item(cmd.kind, cmd.from_state, cmd.to_state, cmd.score);
        if (rst_n && res.valid && res.ready)
            sb.check_result(res.best_state, res.step_done);
        if (rst_n && cfg.valid && cfg.ready)
            sb.note_config(cfg.state_count);
    end

    // Result receiver: before every result it draws a random stall, unless the current phase
    // runs without idling. Ready stays high while it waits for valid.
    initial
    begin
        int stall;
        res.ready <= 1'b0;
        forever
        begin
            stall = idle_on ? $urandom_range(0, 7) : 0;
            if (stall > 0)
            begin
                res.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res.ready <= 1'b1;
            do
                @(posedge clk);
            while (res.valid !== 1'b1);
        end
    end

    // Scores are drawn so that ties, both saturation limits and log(0) all come up often,
    // while full-width random values still exercise every bit of the field.
    function automatic score_t draw_score();
        int k;
        k = $urandom_range(0, 19);
        case (k)
            0:       return IMPOSSIBLE;
            1:       return TOP_SCORE;
            2:       return score_t'(IMPOSSIBLE + 1);
            3, 4:    return score_t'($urandom);
            default: return score_t'(($urandom_range(0, 16) - 8) * 128);
        endcase
    endfunction

    // Presents one item and returns in the time step of its handshake. Valid is only lowered
    // when a gap follows, so back-to-back items never see valid dropped and raised in one step.
    // Anything that waits after this returns must lower valid first.
    task automatic send_item(kind_t kind, int from, int to, score_t score);
        int gap;
        gap = idle_on ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            cmd.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd.valid      <= 1'b1;
        cmd.kind       <= kind;
        cmd.from_state <= STATE_IDX_BITS'(from);
        cmd.to_state   <= STATE_IDX_BITS'(to);
        cmd.score      <= score;
        do
            @(posedge clk);
        while (cmd.ready !== 1'b1);
        if (kind == KIND_WRITE_TRANS)
            trans_set[from][to] = 1'b1;
        else if (kind == KIND_WRITE_INIT)
            init_set[from] = 1'b1;
        sent_items++;
    endtask

    // Emission items ignore the index fields, so those get random values too.
    task automatic send_emission(score_t score);
        send_item(KIND_EMISSION, $urandom_range(0, 15), $urandom_range(0, 15), score);
    endtask

    // Holds the sender until every result that is owed has been taken.
    task automatic pause_until_drained();
        cmd.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    // The state count is only written while the block is idle. Every item gives a result, so
    // once nothing is owed the block has nothing left in flight.
    task automatic write_state_count(int value);
        pause_until_drained();
        cfg.valid       <= 1'b1;
        cfg.state_count <= COUNT_BITS'(value);
        do
            @(posedge clk);
        while (cfg.ready !== 1'b1);
        cfg.valid <= 1'b0;
        active_n = (value < 1) ? 1 : ((value > STATES) ? STATES : value);
        settings_used++;
    endtask

    // Writes every table entry that the current state count can read and that is still empty.
    task automatic fill_tables();
        for (int i = 0; i < active_n; i++)
        begin
            for (int j = 0; j < active_n; j++)
                if (!trans_set[i][j])
                    send_item(KIND_WRITE_TRANS, i, j, draw_score());
            if (!init_set[i])
                send_item(KIND_WRITE_INIT, i, $urandom_range(0, 15), draw_score());
        end
    endtask

    // Directed opening with two states: all four kinds, the extreme indexes and scores,
    // a reload with every state impossible (normalization skipped), saturation at both ends,
    // ties going to the lower index, and a partial step abandoned by a reload. The last
    // emission leaves a partial step that the next state-count write abandons.
    task automatic run_directed();
        send_item(KIND_WRITE_TRANS, 15, 15, TOP_SCORE);
        send_item(KIND_WRITE_INIT, 15, 0, IMPOSSIBLE);
        send_item(KIND_WRITE_TRANS, 0, 0, IMPOSSIBLE);
        write_state_count(2);
        send_item(KIND_WRITE_TRANS, 0, 0, score_t'(-256));
        send_item(KIND_WRITE_TRANS, 0, 1, IMPOSSIBLE);
        send_item(KIND_WRITE_TRANS, 1, 0, 0);
        send_item(KIND_WRITE_TRANS, 1, 1, TOP_SCORE);
        send_item(KIND_WRITE_INIT, 0, 15, IMPOSSIBLE);
        send_item(KIND_WRITE_INIT, 1, 0, IMPOSSIBLE);
        send_item(KIND_RELOAD, 0, 0, 0);
        send_emission(0);
        send_emission(0);
        send_item(KIND_WRITE_INIT, 0, 0, score_t'(-512));
        send_item(KIND_WRITE_INIT, 1, 0, score_t'(-512));
        send_item(KIND_RELOAD, 15, 15, IMPOSSIBLE);
        // Both sums reach the top; the one for state 1 runs past it and sticks at the maximum.
        send_emission(TOP_SCORE);
        send_emission(TOP_SCORE);
        // State 0 ends so low that normalizing pushes it below the range, to impossible.
        send_emission(score_t'(IMPOSSIBLE + 1));
        send_emission(score_t'(-512));
        send_emission(0);
        send_item(KIND_RELOAD, 0, 0, TOP_SCORE);
        send_emission(score_t'(24'h5A5A5A));
    endtask

    // One random phase at the current state count. Most of it is whole update steps with
    // random emissions, since only full steps and reloads move path scores; the rest is table
    // writes at any index, reloads, steps cut short by a reload, stray items and pauses.
    task automatic run_phase(int budget);
        int start;
        int pick;
        int k;
        fill_tables();
        start = sent_items;
        while (sent_items - start < budget)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                repeat (active_n) send_emission(draw_score());
            end
            else if (pick < 70)
            begin
                k = $urandom_range(0, active_n - 1);
                repeat (k) send_emission(draw_score());
                send_item(KIND_RELOAD, $urandom_range(0, 15), $urandom_range(0, 15),
                          draw_score());
            end
            else if (pick < 80)
            begin
                k = $urandom_range(1, 4);
                repeat (k)
                    send_item($urandom_range(0, 1) ? KIND_WRITE_TRANS : KIND_WRITE_INIT,
                              $urandom_range(0, 15), $urandom_range(0, 15), draw_score());
            end
            else if (pick < 88)
            begin
                send_item(KIND_RELOAD, $urandom_range(0, 15), $urandom_range(0, 15),
                          draw_score());
            end
            else if (pick < 94)
            begin
                send_item(kind_t'($urandom_range(0, 3)), $urandom_range(0, 15),
                          $urandom_range(0, 15), draw_score());
            end
            else if (pick < 97)
            begin
                pause_until_drained();
            end
            else
            begin
                idle_on = ($urandom_range(0, 3) != 0);
            end
        end
        random_items += sent_items - start;
        // Half the phases with more than one state stop in the middle of a step, which the
        // next write of the state count abandons.
        if (active_n > 1 && $urandom_range(0, 1))
        begin
            k = $urandom_range(1, active_n - 1);
            repeat (k) send_emission(draw_score());
            random_items += k;
        end
    endtask

    task automatic run_random();
        int phase;
        int value;
        phase = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            value = (phase < 12) ? COUNT_PLAN[phase] : $urandom_range(0, 31);
            // Every fourth phase starts with no gaps and no stalls on either side.
            idle_on = (phase % 4) != 2;
            write_state_count(value);
            run_phase(PHASE_ITEMS);
            phase++;
        end
    endtask

    // Main sequence: reset, directed opening, random phases, then drain and report.
    initial
    begin
        rst_n           <= 1'b0;
        cmd.valid       <= 1'b0;
        cmd.kind        <= KIND_WRITE_TRANS;
        cmd.from_state  <= '0;
        cmd.to_state    <= '0;
        cmd.score       <= '0;
        cfg.valid       <= 1'b0;
        cfg.state_count <= '0;
        idle_on         = 1'b1;
        active_n        = STATES;
        sent_items      = 0;
        random_items    = 0;
        settings_used   = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_random();

        // Wait for every owed result, then give a stray extra result time to show up.
        pause_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        sb.flag_leftovers();

        $display("Checked %0d items over %0d state-count settings: %0d full update steps,",
                 sb.items, settings_used, sb.steps_done);
        $display("%0d reloads, table writes at every index, scores at both saturation limits.",
                 sb.reloads);
        if (sb.errors == 0)
            $display("** hmm_viterbi_max_plus_step: PASSED **");
        else
            $display("** hmm_viterbi_max_plus_step: FAILED **");
        $finish;
    end

endmodule

[filelist.f]
src/hvmps_pkg.sv
src/hvmps_channels.sv
src/hvmps_ram.sv
src/hmm_viterbi_max_plus_step.sv
src/hvmps_checker.sv
sim/hvmps_tb_pkg.sv
sim/hmm_viterbi_max_plus_step_test.sv
